@@ design/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Line pattern matcher package
// Shared types, register codes, match modes and byte helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int PAT_BYTES           = 16;
  localparam int WINDOW              = 16;
  localparam int LEN_W               = 5;
  localparam int PAT_IDX_W           = 4;
  localparam int WIN_IDX_W           = 4;
  localparam int CNT_W               = 32;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 64;
  localparam int MODE_W              = 2;

  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef byte_t pattern_t [PAT_BYTES];

  localparam cfg_idx_t CFG_PAT_LOW  = 2'd0;
  localparam cfg_idx_t CFG_PAT_HIGH = 2'd1;
  localparam cfg_idx_t CFG_PAT_LEN  = 2'd2;
  localparam cfg_idx_t CFG_MODE     = 2'd3;

  localparam mode_t MODE_SUBSTR = 2'd0;
  localparam mode_t MODE_NOCASE = 2'd1;
  localparam mode_t MODE_WORD   = 2'd2;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    logic delim_hit;
    logic token_match;
  } tok_status_t;

  function automatic byte_t fold_byte(input byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) ? byte_t'(c + 8'd32) : c;
  endfunction

  function automatic logic is_delim(input byte_t c);
    return (c == 8'h20) || (c == 8'h2C) || (c == 8'h2E) ||
           (c == 8'h21) || (c == 8'h3F) || (c == 8'h0A);
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

endpackage

`default_nettype wire

@@ design/lpm_window_match.sv @@
// ----------------------------------------------------------------------------
// Line pattern matcher window compare
// Keeps the last sixteen bytes of the line and compares the newest bytes
// against the pattern, with optional ASCII case folding.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_window_match (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire logic            clear,
  input  wire lpm_pkg::byte_t  text_byte,
  input  wire lpm_pkg::pattern_t pattern,
  input  wire lpm_pkg::len_t   eff_len,
  input  wire logic            ignore_case,
  output logic                 window_hit
);
  import lpm_pkg::*;

  byte_t win_r   [WINDOW];
  byte_t win_nxt [WINDOW];
  len_t  count_r;
  len_t  count_nxt;
  logic  all_eq;

  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      win_nxt[k] = win_r[k+1];
    end
    win_nxt[WINDOW-1] = text_byte;
    count_nxt = (count_r < len_t'(WINDOW)) ? len_t'(count_r + len_t'(1)) : count_r;
  end

  always_comb begin
    byte_t t;
    byte_t p;
    logic [WIN_IDX_W-1:0] idx;
    all_eq = 1'b1;
    for (int i = 0; i < PAT_BYTES; i++) begin
      idx = WIN_IDX_W'(len_t'(WINDOW) - eff_len + len_t'(i));
      t   = win_nxt[idx];
      p   = pattern[i];
      if (ignore_case) begin
        t = fold_byte(t);
        p = fold_byte(p);
      end
      if ((len_t'(i) < eff_len) && (t != p)) begin
        all_eq = 1'b0;
      end
    end
    window_hit = (eff_len != '0) && (count_nxt >= eff_len) && all_eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r <= '0;
      for (int k = 0; k < WINDOW; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_en) begin
      count_r <= count_nxt;
      for (int k = 0; k < WINDOW; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= len_t'(WINDOW))
    else $error("window fill count exceeds window depth");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (count_r == '0))
    else $error("window not empty after line end");
  a_hit_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    window_hit |-> (count_nxt >= eff_len && eff_len != '0))
    else $error("window hit with too few bytes in line");
`endif

endmodule

`default_nettype wire

@@ design/lpm_token_match.sv @@
// ----------------------------------------------------------------------------
// Line pattern matcher token tracker
// Follows the current word of the line and checks it for exact equality
// with the pattern; words are split on the delimiter characters.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_token_match #(
  parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              clear,
  input  wire lpm_pkg::byte_t    text_byte,
  input  wire lpm_pkg::pattern_t pattern,
  input  wire lpm_pkg::len_t     eff_len,
  input  wire logic              word_mode,
  output lpm_pkg::tok_status_t   status
);
  import lpm_pkg::*;

  localparam int TPW = $clog2(PATTERN_MAX + 2);
  localparam logic [TPW-1:0] TP_MAX = TPW'(PATTERN_MAX + 1);

  logic [TPW-1:0] tp_r;
  logic [TPW-1:0] tp_nxt;
  logic           mm_r;
  logic           mm_nxt;
  logic           delim;
  logic           tok_match;

  assign delim     = is_delim(text_byte);
  assign tok_match = (eff_len != '0) && (len_t'(tp_r) == eff_len) && !mm_r;

  always_comb begin
    tp_nxt = tp_r;
    mm_nxt = mm_r;
    if (delim) begin
      tp_nxt = '0;
      mm_nxt = 1'b0;
    end else begin
      if ((len_t'(tp_r) >= eff_len) || (text_byte != pattern[PAT_IDX_W'(tp_r)])) begin
        mm_nxt = 1'b1;
      end
      if (tp_r < TP_MAX) begin
        tp_nxt = tp_r + TPW'(1);
      end
    end
  end

  assign status.delim_hit   = delim && word_mode && tok_match;
  assign status.token_match = tok_match;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      tp_r <= '0;
      mm_r <= 1'b0;
    end else if (step) begin
      tp_r <= tp_nxt;
      mm_r <= mm_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_tp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tp_r <= TP_MAX)
    else $error("token position beyond saturation point");
  a_delim_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && delim |=> (tp_r == '0 && !mm_r))
    else $error("token state not reset after delimiter");
  a_match_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    tok_match |-> (eff_len != '0))
    else $error("token match with empty pattern");
`endif

endmodule

`default_nettype wire

@@ design/line_pattern_matcher.sv @@
// A line-end beat passes through the input register and then the result register.
// Throughput: one input beat per cycle. A line-end beat in the input register
// waits while the result register is full and not being read, and holds back
// the beats behind it; text bytes never wait otherwise.
// Reset (rst_n low, synchronous) clears the pattern registers, the line
// state, both counters and all valid flags.
// ----------------------------------------------------------------------------
// Line pattern matcher top level
// Grep-style line matcher: input register, per-byte window and token
// compare, line and match counters and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pattern_matcher #(
  parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lpm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lpm_pkg::byte_t                    in_text_byte,
  input  wire logic                              in_line_done,
  input  wire logic                              in_file_start,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_line_matched,
  output lpm_pkg::cnt_t                          out_line_index,
  output lpm_pkg::cnt_t                          out_matched_lines
);
  import lpm_pkg::*;

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  len_t                  pat_len_r;
  mode_t                 mode_r;

  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_done_r;
  logic  s1_start_r;

  logic  line_hit_r;
  logic  line_hit_nxt;
  cnt_t  line_cnt_r;
  cnt_t  line_cnt_nxt;
  cnt_t  hit_cnt_r;
  cnt_t  hit_cnt_nxt;

  logic  out_valid_r;
  logic  out_matched_r;
  cnt_t  out_line_r;
  cnt_t  out_hits_r;

  pattern_t    pattern;
  len_t        eff_len;
  logic        out_free;
  logic        s1_adv;
  logic        step;
  logic        line_end;
  logic        win_hit;
  logic        substr_mode;
  logic        matched;
  tok_status_t tok;
  cnt_t        line_base;
  cnt_t        hit_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      mode_r     <= MODE_SUBSTR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        CFG_MODE:     mode_r     <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PAT_BYTES / 2; i++) begin
      pattern[i]                 = pat_low_r[8*i +: 8];
      pattern[i + PAT_BYTES / 2] = pat_high_r[8*i +: 8];
    end
  end

  assign eff_len = (pat_len_r > len_t'(PATTERN_MAX)) ? len_t'(PATTERN_MAX) : pat_len_r;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_done_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_adv && !s1_done_r;
  assign line_end = s1_adv && s1_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_text_byte;
      s1_done_r  <= in_line_done;
      s1_start_r <= in_file_start;
    end
  end

  assign substr_mode = (mode_r inside {MODE_SUBSTR, MODE_NOCASE});

  lpm_window_match u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (step),
    .clear      (line_end),
    .text_byte  (s1_byte_r),
    .pattern    (pattern),
    .eff_len    (eff_len),
    .ignore_case(mode_r == MODE_NOCASE),
    .window_hit (win_hit)
  );

  lpm_token_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_token (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .clear    (line_end),
    .text_byte(s1_byte_r),
    .pattern  (pattern),
    .eff_len  (eff_len),
    .word_mode(mode_r == MODE_WORD),
    .status   (tok)
  );

  always_comb begin
    case (mode_r)
      MODE_SUBSTR, MODE_NOCASE: matched = line_hit_r || (eff_len == '0);
      MODE_WORD:                matched = line_hit_r || tok.token_match;
      default:                  matched = 1'b0;
    endcase
  end

  always_comb begin
    line_hit_nxt = line_hit_r;
    if (line_end) begin
      line_hit_nxt = 1'b0;
    end else if (step && ((substr_mode && win_hit) || tok.delim_hit)) begin
      line_hit_nxt = 1'b1;
    end
  end

  always_comb begin
    line_base    = s1_start_r ? '0 : line_cnt_r;
    hit_base     = s1_start_r ? '0 : hit_cnt_r;
    line_cnt_nxt = line_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    if (s1_adv) begin
      line_cnt_nxt = s1_done_r ? sat_inc(line_base) : line_base;
      hit_cnt_nxt  = (s1_done_r && matched) ? sat_inc(hit_base) : hit_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_hit_r <= 1'b0;
      line_cnt_r <= '0;
      hit_cnt_r  <= '0;
    end else begin
      line_hit_r <= line_hit_nxt;
      line_cnt_r <= line_cnt_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (line_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      out_matched_r <= matched;
      out_line_r    <= line_cnt_nxt;
      out_hits_r    <= hit_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_matched  = out_matched_r;
  assign out_line_index    = out_line_r;
  assign out_matched_lines = out_hits_r;

`ifndef NO_ASSERTIONS
  a_hits_le_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hits_r <= out_line_r))
    else $error("matched line count exceeds line number");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_line_r != '0))
    else $error("result beat with line number zero");
  a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_done_r && out_valid_r && !out_ready |=> s1_valid_r && s1_done_r)
    else $error("line-end beat dropped while result register full");
  a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    line_end |=> !line_hit_r)
    else $error("line hit flag survived line end");
`endif

endmodule

`default_nettype wire

@@ tb/line_pattern_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// Line pattern matcher testbench
// Streams text lines into the matcher with random gaps and result-side
// stalls, predicts each line result in the bench and compares every
// returned result field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module line_pattern_matcher_tb;
  import lpm_pkg::*;

  localparam mode_t MODE_SPARE    = 2'd3;
  localparam int    PAT_LIMIT     = PATTERN_MAX_DEFAULT;
  localparam int    LONG_HOLD     = 200;
  localparam int    RANDOM_BEATS  = 850;
  localparam int    SETTLE_CYCLES = 4;

  typedef struct packed {
    logic matched;
    cnt_t index;
    cnt_t count;
  } line_result_t;

  typedef struct {
    bit           is_reg;
    cfg_idx_t     idx;
    logic [63:0]  data;
    byte_t        ch;
    bit           done;
    bit           start;
    bit           known;
    line_result_t want;
  } script_row_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_valid     = 1'b0;
  cfg_idx_t    cfg_index     = '0;
  logic [63:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  byte_t       in_text_byte  = '0;
  logic        in_line_done  = 1'b0;
  logic        in_file_start = 1'b0;
  logic        out_ready     = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic        out_line_matched;
  cnt_t        out_line_index;
  cnt_t        out_matched_lines;

  line_result_t pending_lines[$];
  script_row_t  script[$];
  int           errors;
  int           beats_taken;
  int           random_beats;
  bit           calm;
  bit           held_off;

  // Predicted view of the block: registers, line window, token tracker, counters.
  logic [63:0]  pat_low       = '0;
  logic [63:0]  pat_high      = '0;
  len_t         pat_len       = '0;
  mode_t        cur_mode      = MODE_SUBSTR;
  byte_t        tail [16]     = '{default: 8'h00};
  int unsigned  tail_fill     = 0;
  bit           line_hit_seen = 1'b0;
  int unsigned  word_pos      = 0;
  bit           word_bad      = 1'b0;
  cnt_t         line_num      = '0;
  cnt_t         hit_num       = '0;

  line_pattern_matcher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .in_line_done      (in_line_done),
    .in_file_start     (in_file_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_matched  (out_line_matched),
    .out_line_index    (out_line_index),
    .out_matched_lines (out_matched_lines)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned used_len();
    return (pat_len > PAT_LIMIT) ? PAT_LIMIT : pat_len;
  endfunction

  function automatic byte_t pattern_at(int unsigned i);
    return (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
  endfunction

  function automatic byte_t lower_ascii(byte_t c);
    return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
  endfunction

  function automatic bit is_separator(byte_t c);
    return c == " " || c == "," || c == "." || c == "!" || c == "?" || c == 8'h0A;
  endfunction

  function automatic bit window_hit(bit nocase);
    int unsigned len;
    byte_t t;
    byte_t p;
    len = used_len();
    if (len == 0 || tail_fill < len) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      t = tail[16-len+i];
      p = pattern_at(i);
      if (nocase) begin
        t = lower_ascii(t);
        p = lower_ascii(p);
      end
      if (t != p) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit word_hit();
    return used_len() != 0 && word_pos == used_len() && !word_bad;
  endfunction

  function automatic void clear_line();
    tail = '{default: 8'h00};
    tail_fill = 0;
    line_hit_seen = 1'b0;
    word_pos = 0;
    word_bad = 1'b0;
  endfunction

  function automatic bit predict_line_result(input byte_t c, input bit done, input bit start,
                                             output line_result_t res);
    int unsigned len;
    bit matched;
    len = used_len();
    res = '0;
    if (start) begin
      line_num = '0;
      hit_num = '0;
    end
    if (!done) begin
      for (int i = 0; i < 15; i++) tail[i] = tail[i+1];
      tail[15] = c;
      if (tail_fill < 16) tail_fill++;
      if ((cur_mode == MODE_SUBSTR || cur_mode == MODE_NOCASE) &&
          window_hit(cur_mode == MODE_NOCASE)) line_hit_seen = 1'b1;
      if (is_separator(c)) begin
        if (cur_mode == MODE_WORD && word_hit()) line_hit_seen = 1'b1;
        word_pos = 0;
        word_bad = 1'b0;
      end else begin
        if (word_pos >= len) word_bad = 1'b1;
        else if (c != pattern_at(word_pos)) word_bad = 1'b1;
        if (word_pos < PAT_LIMIT + 1) word_pos++;
      end
      return 1'b0;
    end
    case (cur_mode)
      MODE_SUBSTR, MODE_NOCASE: matched = line_hit_seen || len == 0;
      MODE_WORD:                matched = line_hit_seen || word_hit();
      default:                  matched = 1'b0;
    endcase
    if (line_num != CNT_MAX) line_num++;
    if (matched && hit_num != CNT_MAX) hit_num++;
    res.matched = matched;
    res.index = line_num;
    res.count = hit_num;
    clear_line();
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic byte_t pick_letter();
    case ($urandom_range(0, 4))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      default: return "c";
    endcase
  endfunction

  function automatic byte_t pick_separator();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return ",";
      2: return ".";
      3: return "!";
      4: return "?";
      default: return 8'h0A;
    endcase
  endfunction

  function automatic void add_text(byte_t ch, bit start);
    script.push_back('{1'b0, '0, '0, ch, 1'b0, start, 1'b0, '0});
  endfunction

  function automatic void add_end(bit start);
    script.push_back('{1'b0, '0, '0, 8'hA5, 1'b1, start, 1'b0, '0});
  endfunction

  function automatic void add_end_known(bit start, logic m, cnt_t n, cnt_t k);
    line_result_t want;
    want.matched = m;
    want.index = n;
    want.count = k;
    script.push_back('{1'b0, '0, '0, 8'h5A, 1'b1, start, 1'b1, want});
  endfunction

  function automatic void add_reg(cfg_idx_t idx, logic [63:0] data);
    script.push_back('{1'b1, idx, data, '0, 1'b0, 1'b0, 1'b0, '0});
  endfunction

  task automatic send_beat(input byte_t ch, input bit done, input bit start,
                           input bit known, input line_result_t want);
    int gap;
    line_result_t res;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= ch;
    in_line_done <= done;
    in_file_start <= start;
    do @(posedge clk); while (!in_ready);
    beats_taken++;
    if (predict_line_result(ch, done, start, res)) pending_lines.push_back(known ? want : res);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAT_LOW:  pat_low = data;
      CFG_PAT_HIGH: pat_high = data;
      CFG_PAT_LEN:  pat_len = data[LEN_W-1:0];
      default:      cur_mode = data[MODE_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_line(input bit finish);
    byte_t text[$];
    int target;
    int r;
    int unsigned len;
    byte_t b;
    len = used_len();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
    while (text.size() < target) begin
      r = $urandom_range(0, 9);
      if (r < 3 && len != 0) begin
        if (cur_mode == MODE_WORD && $urandom_range(0, 1)) text.push_back(pick_separator());
        for (int unsigned i = 0; i < len; i++) begin
          b = pattern_at(i);
          if (cur_mode == MODE_NOCASE && lower_ascii(b) != b && $urandom_range(0, 1))
            b = lower_ascii(b);
          else if (cur_mode == MODE_NOCASE && b >= "a" && b <= "z" && $urandom_range(0, 1))
            b = byte_t'(b - 8'd32);
          text.push_back(b);
        end
        if (cur_mode == MODE_WORD && $urandom_range(0, 1)) text.push_back(pick_separator());
      end else if (r < 5) begin
        text.push_back(pick_separator());
      end else if (r == 5) begin
        text.push_back(byte_t'($urandom_range(0, 255)));
      end else begin
        text.push_back(pick_letter());
      end
    end
    foreach (text[i]) send_beat(text[i], 1'b0, $urandom_range(0, 39) == 0, 1'b0, '0);
    if (finish)
      send_beat(byte_t'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 14) == 0, 1'b0, '0);
    random_beats += text.size() + int'(finish);
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        $display("%0t: unexpected result matched=%0d line=%0d count=%0d", $time,
                 out_line_matched, out_line_index, out_matched_lines);
        errors++;
      end else begin
        want = pending_lines.pop_front();
        if (out_line_matched !== want.matched) begin
          $display("%0t: line_matched expected %0d got %0d", $time, want.matched,
                   out_line_matched);
          errors++;
        end
        if (out_line_index !== want.index) begin
          $display("%0t: line_index expected %0d got %0d", $time, want.index, out_line_index);
          errors++;
        end
        if (out_matched_lines !== want.count) begin
          $display("%0t: matched_lines expected %0d got %0d", $time, want.count,
                   out_matched_lines);
          errors++;
        end
      end
    end
  end

  // The long hold is repeated until the input has been seen stalled during one.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      if (!held_off && beats_taken >= 400) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          if (in_valid && !in_ready) held_off = 1'b1;
        end
      end
      stall = gap_len();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] extra;
    len_t        nlen;
    mode_t       nmode;
    bit          full;
    int          r;
    int          n_lines;

    add_end_known(1'b0, 1'b1, 1, 1);
    add_text(8'h00, 1'b0);
    add_text(8'hFF, 1'b0);
    add_end_known(1'b0, 1'b1, 2, 2);
    add_text("a", 1'b1);
    add_end_known(1'b0, 1'b1, 1, 1);
    add_end_known(1'b1, 1'b1, 1, 1);
    add_reg(CFG_MODE, 64'(MODE_WORD));
    add_text("x", 1'b0);
    add_end_known(1'b0, 1'b0, 2, 1);
    add_reg(CFG_PAT_LOW, 64'h0000_0000_FF00_4261);
    add_reg(CFG_PAT_LEN, 64'd4);
    add_reg(CFG_MODE, 64'(MODE_NOCASE));
    add_text("A", 1'b0);
    add_text("b", 1'b0);
    add_text(8'h00, 1'b0);
    add_text(8'hFF, 1'b0);
    add_end(1'b0);
    add_reg(CFG_MODE, 64'(MODE_SUBSTR));
    add_text("A", 1'b0);
    add_text("b", 1'b0);
    add_text(8'h00, 1'b0);
    add_text(8'hFF, 1'b0);
    add_end(1'b0);
    add_reg(CFG_MODE, 64'(MODE_SPARE));
    add_end(1'b0);
    add_reg(CFG_PAT_LOW, 64'h6968);
    add_reg(CFG_PAT_LEN, 64'd2);
    add_reg(CFG_MODE, 64'(MODE_WORD));
    add_text("h", 1'b0);
    add_text("i", 1'b0);
    add_text(" ", 1'b0);
    add_end(1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_beat(script[i].ch, script[i].done, script[i].start, script[i].known,
                  script[i].want);
      end
    end

    while (random_beats < RANDOM_BEATS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      full = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < 16; i++) begin
        if (i < 8) lo[8*i +: 8] = full ? byte_t'($urandom_range(0, 255)) : pick_letter();
        else hi[8*(i-8) +: 8] = full ? byte_t'($urandom_range(0, 255)) : pick_letter();
      end
      r = $urandom_range(0, 9);
      if (r == 0) nlen = '0;
      else if (r == 1) nlen = len_t'(PAT_LIMIT);
      else if (r == 2) nlen = len_t'($urandom_range(PAT_LIMIT + 1, 31));
      else nlen = len_t'($urandom_range(1, 5));
      r = $urandom_range(0, 9);
      if (r == 0) nmode = MODE_SPARE;
      else if (r < 4) nmode = MODE_SUBSTR;
      else if (r < 7) nmode = MODE_NOCASE;
      else nmode = MODE_WORD;
      write_reg(CFG_PAT_LOW, lo);
      write_reg(CFG_PAT_HIGH, hi);
      extra = {$urandom, $urandom};
      extra[LEN_W-1:0] = nlen;
      write_reg(CFG_PAT_LEN, extra);
      extra = {$urandom, $urandom};
      extra[MODE_W-1:0] = nmode;
      write_reg(CFG_MODE, extra);
      n_lines = $urandom_range(4, 10);
      for (int k = 0; k < n_lines; k++) send_line(k != n_lines - 1 || $urandom_range(0, 3) != 0);
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
